### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the swipe recogniser modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgr: next-cycle check failed");

`endif

### src/sgr_pkg.sv
// ---------------------------------------------------------------------------
// sgr_pkg
// Codes, command and status types shared by the swipe recogniser.
// ---------------------------------------------------------------------------
package sgr_pkg;

	// Operation codes on the mode field
	localparam logic [2:0] MODE_DOWN   = 3'd0;
	localparam logic [2:0] MODE_MOTION = 3'd1;
	localparam logic [2:0] MODE_UP     = 3'd2;
	localparam logic [2:0] MODE_DETACH = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;
	localparam logic [2:0] MODE_TAKE   = 3'd5;

	// Recogniser status codes
	localparam logic [2:0] ST_RECOG  = 3'd0;
	localparam logic [2:0] ST_FAILED = 3'd1;
	localparam logic [2:0] ST_READY  = 3'd2;
	localparam logic [2:0] ST_HOLD   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	// Per-slot event phases
	localparam logic [2:0] PH_NONE        = 3'd0;
	localparam logic [2:0] PH_START_READY = 3'd1;
	localparam logic [2:0] PH_STARTED     = 3'd2;
	localparam logic [2:0] PH_END_READY   = 3'd3;
	localparam logic [2:0] PH_ENDED       = 3'd4;

	// Event kinds reported on take event
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_TIME_LIMIT = 1'b0;
	localparam logic CFG_DIST_LIMIT = 1'b1;

	localparam logic [31:0] TIME_LIMIT_RST = 32'd300;
	localparam logic [15:0] DIST_LIMIT_RST = 16'd6554;

	// Controller to datapath
	typedef struct packed {
		logic cap_en;    // capture the input transaction
		logic sweep_en;  // walk the slot table for a tick
		logic rd_en;     // read the addressed slot
		logic calc_en;   // form deltas and timeout
		logic sq_en;     // square the deltas and the limit
		logic apply_en;  // update the slot and load the result
	} sgr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_tick;
		logic sweep_done;
		logic out_free;
	} sgr_sts_t;

	function automatic logic [2:0] phase_status(input logic [2:0] ph);
		logic [2:0] st;
		case (ph)
			PH_START_READY: st = ST_READY;
			PH_END_READY:   st = ST_READY;
			PH_STARTED:     st = ST_HOLD;
			PH_ENDED:       st = ST_DONE;
			default:        st = ST_FAILED;
		endcase
		return st;
	endfunction

endpackage

### src/swipe_gesture_recognizer.sv
// A result is loaded in the apply step, after the read, calc and square steps (and the
// sweep for a tick). No new transaction is accepted until the last one has applied; the tick
// sweep reads one slot a cycle through the single read port of the slot memories.
// A waiting result does not hold back acceptance of the next transaction.
// Reset clears all candidate flags and event phases at once and restores the
// limits to 300 ms and 6554; slot payload stays undefined until written.
// ---------------------------------------------------------------------------
// swipe_gesture_recognizer
// Per-slot swipe detector: candidate tracking, distance test, event hand-off.
// ---------------------------------------------------------------------------
module swipe_gesture_recognizer #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [31:0]        cfg_wdata,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [3:0]         finger_slot,
	input  logic [15:0]        pos_x,
	input  logic [15:0]        pos_y,
	input  logic [31:0]        time_ms,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [1:0]         event_kind,
	output logic [15:0]        start_x,
	output logic [15:0]        start_y,
	output logic [31:0]        start_time,
	output logic signed [16:0] delta_x,
	output logic signed [16:0] delta_y
);

	// The controller sequences each transaction; the datapath owns every
	// storage element of the slot table and the result register.
	sgr_pkg::sgr_cmd_t cmd;
	sgr_pkg::sgr_sts_t sts;

	// Sequence: capture, sweep (tick only), read slot, form deltas and
	// timeout, square, then apply once the result register has room.
	sgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the slot table, limits and arithmetic; drop timed-out candidates
	// during a tick and report the addressed slot on every transaction.
	sgr_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.finger_slot (finger_slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.event_kind  (event_kind),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_time  (start_time),
		.delta_x     (delta_x),
		.delta_y     (delta_y)
	);

endmodule

### src/sgr_ctrl.sv
// ---------------------------------------------------------------------------
// sgr_ctrl
// Sequencer: steps one transaction through sweep, read, calc, square, apply.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sgr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sgr_pkg::sgr_sts_t sts,
	output sgr_pkg::sgr_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_READ,
		S_CALC,
		S_SQUARE,
		S_APPLY
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (!sts.is_tick || sts.sweep_done) state_q <= S_READ;
				end
				S_READ:   state_q <= S_CALC;
				S_CALC:   state_q <= S_SQUARE;
				S_SQUARE: state_q <= S_APPLY;
				S_APPLY: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.cap_en   = (state_q == S_IDLE) && in_valid;
	assign cmd.sweep_en = (state_q == S_SWEEP) && sts.is_tick;
	assign cmd.rd_en    = (state_q == S_READ);
	assign cmd.calc_en  = (state_q == S_CALC);
	assign cmd.sq_en    = (state_q == S_SQUARE);
	assign cmd.apply_en = (state_q == S_APPLY) && sts.out_free;

	`SGR_ASSERT_IMPL(a_apply_needs_room, clk, arst_n, cmd.apply_en, sts.out_free)
	`SGR_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

### src/sgr_datapath.sv
// ---------------------------------------------------------------------------
// sgr_datapath
// Slot table, configuration registers, distance arithmetic, result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sgr_datapath #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sgr_pkg::sgr_cmd_t  cmd,
	output sgr_pkg::sgr_sts_t  sts,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic [2:0]         mode,
	input  logic [3:0]         finger_slot,
	input  logic [15:0]        pos_x,
	input  logic [15:0]        pos_y,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [1:0]         event_kind,
	output logic [15:0]        start_x,
	output logic [15:0]        start_y,
	output logic [31:0]        start_time,
	output logic signed [16:0] delta_x,
	output logic signed [16:0] delta_y
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

	// Configuration
	logic [31:0] time_limit_q;
	logic [15:0] dist_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_limit_q <= sgr_pkg::TIME_LIMIT_RST;
			dist_limit_q <= sgr_pkg::DIST_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				sgr_pkg::CFG_TIME_LIMIT: time_limit_q <= cfg_wdata;
				sgr_pkg::CFG_DIST_LIMIT: dist_limit_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Captured transaction
	logic [2:0]  mode_q;
	logic [3:0]  slot_q;
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;
	logic [31:0] time_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			mode_q  <= mode;
			slot_q  <= finger_slot;
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			time_q  <= time_ms;
		end
	end

	logic [EXT_W-1:0] slot_ext;
	logic             in_range;
	logic [IDX_W-1:0] idx;

	assign slot_ext = EXT_W'(slot_q);
	assign in_range = ({28'd0, slot_q} < 32'(SLOTS));
	assign idx      = in_range ? slot_ext[IDX_W-1:0] : '0;

	// Slot table: valid bits and phases in flops, payload in memories
	logic [SLOTS-1:0] cand_valid_q;
	logic [2:0]       phase_q [SLOTS];

	logic [15:0]        cand_x_mem [SLOTS];
	logic [15:0]        cand_y_mem [SLOTS];
	logic [31:0]        cand_t_mem [SLOTS];
	logic [15:0]        ev_sx_mem  [SLOTS];
	logic [15:0]        ev_sy_mem  [SLOTS];
	logic [31:0]        ev_st_mem  [SLOTS];
	logic signed [16:0] ev_dx_mem  [SLOTS];
	logic signed [16:0] ev_dy_mem  [SLOTS];

	// Tick sweep
	logic [CNT_W-1:0] swp_cnt_q;
	logic             swp_issue;
	logic             swp_vld_s1;
	logic [IDX_W-1:0] swp_idx_s1;

	assign swp_issue = cmd.sweep_en && (swp_cnt_q < CNT_W'(SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_cnt_q  <= '0;
			swp_vld_s1 <= 1'b0;
		end else if (cmd.cap_en) begin
			swp_cnt_q  <= '0;
			swp_vld_s1 <= 1'b0;
		end else begin
			swp_vld_s1 <= swp_issue;
			if (swp_issue) swp_cnt_q <= swp_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (swp_issue) swp_idx_s1 <= swp_cnt_q[IDX_W-1:0];
	end

	// Shared read port
	logic [IDX_W-1:0]   rd_addr;
	logic [15:0]        rd_cx_q;
	logic [15:0]        rd_cy_q;
	logic [31:0]        rd_ct_q;
	logic [15:0]        rd_sx_q;
	logic [15:0]        rd_sy_q;
	logic [31:0]        rd_st_q;
	logic signed [16:0] rd_dx_q;
	logic signed [16:0] rd_dy_q;

	assign rd_addr = swp_issue ? swp_cnt_q[IDX_W-1:0] : idx;

	always_ff @(posedge clk) begin
		if (swp_issue || cmd.rd_en) begin
			rd_cx_q <= cand_x_mem[rd_addr];
			rd_cy_q <= cand_y_mem[rd_addr];
			rd_ct_q <= cand_t_mem[rd_addr];
			rd_sx_q <= ev_sx_mem[rd_addr];
			rd_sy_q <= ev_sy_mem[rd_addr];
			rd_st_q <= ev_st_mem[rd_addr];
			rd_dx_q <= ev_dx_mem[rd_addr];
			rd_dy_q <= ev_dy_mem[rd_addr];
		end
	end

	// Elapsed time since the candidate began, wrapping
	logic [31:0] elapsed;
	logic        expired;

	assign elapsed = time_q - rd_ct_q;
	assign expired = (elapsed > time_limit_q);

	// Stage 1: deltas, magnitudes, timeout
	logic signed [16:0] dx_c;
	logic signed [16:0] dy_c;
	logic signed [16:0] ndx_c;
	logic signed [16:0] ndy_c;
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;
	logic [15:0]        ax_s1;
	logic [15:0]        ay_s1;
	logic               tout_s1;

	assign dx_c  = $signed({1'b0, pos_x_q}) - $signed({1'b0, rd_cx_q});
	assign dy_c  = $signed({1'b0, pos_y_q}) - $signed({1'b0, rd_cy_q});
	assign ndx_c = -dx_c;
	assign ndy_c = -dy_c;

	always_ff @(posedge clk) begin
		if (cmd.calc_en) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			ax_s1   <= dx_c[16] ? ndx_c[15:0] : dx_c[15:0];
			ay_s1   <= dy_c[16] ? ndy_c[15:0] : dy_c[15:0];
			tout_s1 <= expired;
		end
	end

	// Stage 2: squares
	logic [31:0] ax2_s2;
	logic [31:0] ay2_s2;
	logic [31:0] lim2_s2;

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			ax2_s2  <= 32'(ax_s1) * 32'(ax_s1);
			ay2_s2  <= 32'(ay_s1) * 32'(ay_s1);
			lim2_s2 <= 32'(dist_limit_q) * 32'(dist_limit_q);
		end
	end

	logic [32:0] d2;
	logic        far_enough;

	assign d2         = {1'b0, ax2_s2} + {1'b0, ay2_s2};
	assign far_enough = (d2 >= {1'b0, lim2_s2});

	// Apply: decide the slot update and the result
	logic       cv_cur;
	logic [2:0] ph_cur;
	logic       cv_nxt;
	logic [2:0] ph_nxt;
	logic [2:0] st_nxt;
	logic [1:0] kind_nxt;
	logic       cand_wr;
	logic       ev_wr;
	logic       upd;

	assign cv_cur = cand_valid_q[idx];
	assign ph_cur = phase_q[idx];
	assign upd    = cmd.apply_en && in_range;

	always_comb begin
		cv_nxt   = cv_cur;
		ph_nxt   = ph_cur;
		st_nxt   = sgr_pkg::ST_FAILED;
		kind_nxt = sgr_pkg::KIND_NONE;
		cand_wr  = 1'b0;
		ev_wr    = 1'b0;
		case (mode_q)
			sgr_pkg::MODE_DOWN: begin
				cv_nxt  = 1'b1;
				cand_wr = 1'b1;
				st_nxt  = sgr_pkg::ST_RECOG;
			end
			sgr_pkg::MODE_MOTION: begin
				if (cv_cur) begin
					if (tout_s1) begin
						cv_nxt = 1'b0;
						st_nxt = sgr_pkg::ST_FAILED;
					end else if (far_enough) begin
						cv_nxt = 1'b0;
						ph_nxt = sgr_pkg::PH_START_READY;
						ev_wr  = 1'b1;
						st_nxt = sgr_pkg::ST_READY;
					end else begin
						st_nxt = sgr_pkg::ST_RECOG;
					end
				end else begin
					st_nxt = sgr_pkg::phase_status(ph_cur);
				end
			end
			sgr_pkg::MODE_UP: begin
				if (ph_cur != sgr_pkg::PH_NONE) begin
					ph_nxt = sgr_pkg::PH_END_READY;
					st_nxt = sgr_pkg::ST_READY;
				end
			end
			sgr_pkg::MODE_DETACH: begin
				cv_nxt = 1'b0;
				ph_nxt = sgr_pkg::PH_NONE;
				st_nxt = sgr_pkg::ST_FAILED;
			end
			sgr_pkg::MODE_TAKE: begin
				if (ph_cur == sgr_pkg::PH_START_READY) begin
					ph_nxt   = sgr_pkg::PH_STARTED;
					kind_nxt = sgr_pkg::KIND_START;
				end else if (ph_cur == sgr_pkg::PH_END_READY) begin
					ph_nxt   = sgr_pkg::PH_ENDED;
					kind_nxt = sgr_pkg::KIND_END;
				end
				st_nxt = cv_cur ? sgr_pkg::ST_RECOG : sgr_pkg::phase_status(ph_nxt);
			end
			default: begin
				st_nxt = cv_cur ? sgr_pkg::ST_RECOG : sgr_pkg::phase_status(ph_cur);
			end
		endcase
		if (!in_range) begin
			cv_nxt   = cv_cur;
			ph_nxt   = ph_cur;
			st_nxt   = sgr_pkg::ST_FAILED;
			kind_nxt = sgr_pkg::KIND_NONE;
			cand_wr  = 1'b0;
			ev_wr    = 1'b0;
		end
	end

	// Valid bits and phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) phase_q[i] <= sgr_pkg::PH_NONE;
		end else begin
			if (swp_vld_s1 && cand_valid_q[swp_idx_s1] && expired) begin
				cand_valid_q[swp_idx_s1] <= 1'b0;
			end
			if (upd) begin
				cand_valid_q[idx] <= cv_nxt;
				phase_q[idx]      <= ph_nxt;
			end
		end
	end

	// Payload memories
	always_ff @(posedge clk) begin
		if (upd && cand_wr) begin
			cand_x_mem[idx] <= pos_x_q;
			cand_y_mem[idx] <= pos_y_q;
			cand_t_mem[idx] <= time_q;
		end
		if (upd && ev_wr) begin
			ev_sx_mem[idx] <= rd_cx_q;
			ev_sy_mem[idx] <= rd_cy_q;
			ev_st_mem[idx] <= rd_ct_q;
			ev_dx_mem[idx] <= dx_s1;
			ev_dy_mem[idx] <= dy_s1;
		end
	end

	// Result register
	logic       out_valid_q;
	logic       has_ev;

	assign has_ev = (kind_nxt != sgr_pkg::KIND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_en) begin
			status     <= st_nxt;
			event_kind <= kind_nxt;
			start_x    <= has_ev ? rd_sx_q : '0;
			start_y    <= has_ev ? rd_sy_q : '0;
			start_time <= has_ev ? rd_st_q : '0;
			delta_x    <= has_ev ? rd_dx_q : '0;
			delta_y    <= has_ev ? rd_dy_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.is_tick    = (mode_q == sgr_pkg::MODE_TICK);
	assign sts.sweep_done = (swp_cnt_q == CNT_W'(SLOTS)) && !swp_vld_s1;

	`SGR_ASSERT_NEXT(a_apply_loads_result, clk, arst_n, cmd.apply_en, out_valid)
	`SGR_ASSERT_IMPL(a_sweep_only_on_tick, clk, arst_n, swp_vld_s1 || swp_issue, sts.is_tick)

endmodule
